FILE: rtl/nmgs_pkg.sv
// Shared types and constants of the neighbour mean grid smoother.
// Used by the quotient cells, the top level and the checker.
package nmgs_pkg;

   localparam int ROW_LENGTH_W = 11;
   localparam int ROW_COUNT_W  = 16;
   localparam int CSR_DW       = 16;
   localparam int DIVISOR_W    = 3;

   localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RESET = ROW_LENGTH_W'(1024);
   localparam logic [ROW_COUNT_W-1:0]  ROW_COUNT_RESET  = ROW_COUNT_W'(1024);

   typedef enum logic {
      REG_ROW_LENGTH = 1'b0,
      REG_ROW_COUNT  = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic res;
      logic has_up;
      logic has_down;
      logic has_left;
      logic has_right;
      logic last;
   } item_flags_type;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [DIVISOR_W-1:0] divisor;
      logic [DIVISOR_W-1:0] rem;
   } div_ctl_type;

endpackage

FILE: rtl/nmgs_line_store.sv
// Line store holding the upper and center row entries of each column.
// One write port and two registered read ports; no package dependencies.
module nmgs_line_store #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 30
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_WIDTH-1:0]    wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [DATA_WIDTH-1:0]    rdata_a,
   output logic [DATA_WIDTH-1:0]    rdata_b
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_a_ff;
   logic [DATA_WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= mem[raddr_a];
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

FILE: rtl/nmgs_div_cell.sv
// One cell of the quotient chain: a restoring division step for one bit.
// Depends on nmgs_pkg for the control struct passed between cells.
module nmgs_div_cell #(
   parameter int NUM_WIDTH = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  nmgs_pkg::div_ctl_type ctl_in,
   input  logic [NUM_WIDTH-1:0]  num_in,
   output nmgs_pkg::div_ctl_type ctl_out,
   output logic [NUM_WIDTH-1:0]  num_out
);

   logic [nmgs_pkg::DIVISOR_W:0]   trial;
   logic [nmgs_pkg::DIVISOR_W:0]   divisor_ext;
   logic                           fits;
   logic [nmgs_pkg::DIVISOR_W-1:0] rem_in;
   nmgs_pkg::div_ctl_type          ctl_ff;
   logic [NUM_WIDTH-1:0]           num_ff;

   always_comb begin
      trial       = {ctl_in.rem, num_in[NUM_WIDTH-1]};
      divisor_ext = {1'b0, ctl_in.divisor};
      fits        = trial >= divisor_ext;
      if (fits) begin
         rem_in = nmgs_pkg::DIVISOR_W'(trial - divisor_ext);
      end else begin
         rem_in = trial[nmgs_pkg::DIVISOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff.valid   <= ctl_in.valid;
         ctl_ff.last    <= ctl_in.last;
         ctl_ff.divisor <= ctl_in.divisor;
         ctl_ff.rem     <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= {num_in[NUM_WIDTH-2:0], fits};
      end
   end

   assign ctl_out = ctl_ff;
   assign num_out = num_ff;

endmodule

FILE: rtl/neighbour_mean_grid_smoother.sv
// Throughput: one item per cycle while the output queue is not full, set by the line
// store (one write and two read ports per cycle) and by the quotient chain, one cell
// per quotient bit.
// Reset clears counters, pipeline and output queue and sets both registers to 1024;
// the line stores are not cleared.
module neighbour_mean_grid_smoother #(
   parameter int MAX_ROW_LENGTH = 1024,
   parameter int VALUE_WIDTH    = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // height_value, zero padded to whole bytes.
   input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       req_tdata,
   // action.
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // smoothed_value, zero padded to whole bytes.
   output logic [((VALUE_WIDTH+6)/8)*8-1:0]       rsp_tdata,
   output logic                                   rsp_tlast,
   input  logic                                   csr_we,
   input  logic                                   csr_index,
   input  logic [nmgs_pkg::CSR_DW-1:0]            csr_wdata
);

   localparam int AW     = $clog2(MAX_ROW_LENGTH);
   localparam int W      = VALUE_WIDTH - 1;
   localparam int SW     = VALUE_WIDTH + 2;
   localparam int LENW   = (AW + 1 > nmgs_pkg::ROW_LENGTH_W) ? AW + 1 : nmgs_pkg::ROW_LENGTH_W;
   localparam int RSP_DW = ((VALUE_WIDTH + 6) / 8) * 8;

   logic [nmgs_pkg::ROW_LENGTH_W-1:0] row_length_ff;
   logic [nmgs_pkg::ROW_COUNT_W-1:0]  row_count_ff;
   logic [AW-1:0]                     col_ff;
   logic [nmgs_pkg::ROW_COUNT_W-1:0]  row_ff;

   logic [LENW-1:0]                   len_raw;
   logic [LENW-1:0]                   eff_len;
   logic [nmgs_pkg::ROW_COUNT_W-1:0]  rows_eff;
   logic [LENW-1:0]                   col_next;
   logic                              last_col;
   logic                              draining;
   logic                              is_flush;
   logic                              effective;
   logic                              accept;
   logic                              en;
   nmgs_pkg::item_flags_type          in_flags;
   logic [VALUE_WIDTH-1:0]            height;
   logic [W-1:0]                      clamped;

   logic                              s1_valid_ff;
   nmgs_pkg::item_flags_type          s1_flags_ff;
   logic [AW-1:0]                     s1_addr_ff;
   logic [W-1:0]                      s1_v_ff;
   logic                              fwd_a_ff;
   logic                              fwd_b_ff;
   logic [W-1:0]                      fwd_upper_ff;
   logic [W-1:0]                      fwd_center_ff;
   logic [W-1:0]                      left_ff;

   logic [2*W-1:0]                    rdata_a;
   logic [2*W-1:0]                    rdata_b;
   logic [W-1:0]                      upper_c;
   logic [W-1:0]                      center_c;
   logic [W-1:0]                      right_c;
   logic [W-1:0]                      wr_upper;
   logic [W-1:0]                      wr_center;
   logic [SW-1:0]                     sum;
   logic [nmgs_pkg::DIVISOR_W-1:0]    cells;

   nmgs_pkg::div_ctl_type             head_ctl_ff;
   logic [SW-1:0]                     head_num_ff;
   nmgs_pkg::div_ctl_type             ctl_chain [SW+1];
   logic [SW-1:0]                     num_chain [SW+1];

   logic [W-1:0]                      fifo_val_ff [2];
   logic                              fifo_last_ff [2];
   logic                              wr_ptr_ff;
   logic                              rd_ptr_ff;
   logic [1:0]                        count_ff;
   logic                              push;
   logic                              pop;

   always_comb begin
      len_raw = LENW'(row_length_ff);
      if (len_raw == '0) begin
         eff_len = LENW'(1);
      end else if (len_raw > LENW'(MAX_ROW_LENGTH)) begin
         eff_len = LENW'(MAX_ROW_LENGTH);
      end else begin
         eff_len = len_raw;
      end
      rows_eff  = (row_count_ff == '0) ? nmgs_pkg::ROW_COUNT_W'(1) : row_count_ff;
      col_next  = LENW'(col_ff) + LENW'(1);
      last_col  = col_next >= eff_len;
      draining  = row_ff >= rows_eff;
      is_flush  = req_tuser;
      effective = is_flush ? draining : !draining;

      in_flags.res       = is_flush || (row_ff != '0);
      in_flags.has_up    = is_flush ? (rows_eff >= nmgs_pkg::ROW_COUNT_W'(2))
                                    : (row_ff >= nmgs_pkg::ROW_COUNT_W'(2));
      in_flags.has_down  = !is_flush;
      in_flags.has_left  = col_ff != '0;
      in_flags.has_right = !last_col;
      in_flags.last      = is_flush && last_col;

      height  = req_tdata[VALUE_WIDTH-1:0];
      clamped = height[VALUE_WIDTH-1] ? '0 : height[W-1:0];
   end

   assign en         = count_ff != 2'd2;
   assign req_tready = en;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= nmgs_pkg::ROW_LENGTH_RESET;
         row_count_ff  <= nmgs_pkg::ROW_COUNT_RESET;
         col_ff        <= '0;
         row_ff        <= '0;
      end else if (csr_we) begin
         case (nmgs_pkg::csr_reg_type'(csr_index))
            nmgs_pkg::REG_ROW_LENGTH: begin
               row_length_ff <= csr_wdata[nmgs_pkg::ROW_LENGTH_W-1:0];
               col_ff        <= '0;
               row_ff        <= '0;
            end
            nmgs_pkg::REG_ROW_COUNT: begin
               row_count_ff <= csr_wdata[nmgs_pkg::ROW_COUNT_W-1:0];
               col_ff       <= '0;
               row_ff       <= '0;
            end
            default: begin
            end
         endcase
      end else if (accept && effective) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= is_flush ? '0 : row_ff + nmgs_pkg::ROW_COUNT_W'(1);
         end else begin
            col_ff <= col_next[AW-1:0];
         end
      end
   end

   // The item in the first stage writes its column on the same edge at which the
   // next item reads, so matching read addresses take the written data instead.
   always_comb begin
      upper_c   = fwd_a_ff ? fwd_upper_ff  : rdata_a[2*W-1:W];
      center_c  = fwd_a_ff ? fwd_center_ff : rdata_a[W-1:0];
      right_c   = fwd_b_ff ? fwd_center_ff : rdata_b[W-1:0];
      wr_upper  = center_c;
      wr_center = s1_flags_ff.has_down ? s1_v_ff : center_c;

      sum = SW'(center_c)
          + (s1_flags_ff.has_up    ? SW'(upper_c) : '0)
          + (s1_flags_ff.has_down  ? SW'(s1_v_ff) : '0)
          + (s1_flags_ff.has_left  ? SW'(left_ff) : '0)
          + (s1_flags_ff.has_right ? SW'(right_c) : '0);
      cells = nmgs_pkg::DIVISOR_W'(1)
            + nmgs_pkg::DIVISOR_W'(s1_flags_ff.has_up)
            + nmgs_pkg::DIVISOR_W'(s1_flags_ff.has_down)
            + nmgs_pkg::DIVISOR_W'(s1_flags_ff.has_left)
            + nmgs_pkg::DIVISOR_W'(s1_flags_ff.has_right);
   end

   nmgs_line_store #(
      .DEPTH      (MAX_ROW_LENGTH),
      .DATA_WIDTH (2 * W)
   ) u_line_store (
      .clock   (clock),
      .we      (en && s1_valid_ff),
      .waddr   (s1_addr_ff),
      .wdata   ({wr_upper, wr_center}),
      .re      (en),
      .raddr_a (col_ff),
      .raddr_b (col_next[AW-1:0]),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         head_ctl_ff <= '0;
      end else if (en) begin
         s1_valid_ff         <= accept && effective;
         head_ctl_ff.valid   <= s1_valid_ff && s1_flags_ff.res;
         head_ctl_ff.last    <= s1_flags_ff.last;
         head_ctl_ff.divisor <= cells;
         head_ctl_ff.rem     <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_flags_ff   <= in_flags;
         s1_addr_ff    <= col_ff;
         s1_v_ff       <= clamped;
         fwd_a_ff      <= s1_valid_ff && (s1_addr_ff == col_ff);
         fwd_b_ff      <= s1_valid_ff && (s1_addr_ff == col_next[AW-1:0]);
         fwd_upper_ff  <= wr_upper;
         fwd_center_ff <= wr_center;
         head_num_ff   <= sum;
         if (s1_valid_ff) begin
            left_ff <= center_c;
         end
      end
   end

   assign ctl_chain[0] = head_ctl_ff;
   assign num_chain[0] = head_num_ff;

   for (genvar i = 0; i < SW; i++) begin : g_cell
      nmgs_div_cell #(
         .NUM_WIDTH (SW)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_in  (ctl_chain[i]),
         .num_in  (num_chain[i]),
         .ctl_out (ctl_chain[i+1]),
         .num_out (num_chain[i+1])
      );
   end

   assign push = en && ctl_chain[SW].valid;
   assign pop  = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_val_ff[wr_ptr_ff]  <= num_chain[SW][W-1:0];
         fifo_last_ff[wr_ptr_ff] <= ctl_chain[SW].last;
      end
   end

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = RSP_DW'(fifo_val_ff[rd_ptr_ff]);
   assign rsp_tlast  = fifo_last_ff[rd_ptr_ff];

endmodule

FILE: rtl/nmgs_checker.sv
// Port-level checks for the neighbour mean grid smoother, bound to the top level.
// Sees only top-level ports; no package dependencies.
module nmgs_port_checker #(
   parameter int VALUE_WIDTH = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((VALUE_WIDTH+6)/8)*8-1:0]   rsp_tdata,
   input logic                               rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >> (VALUE_WIDTH - 1)) == '0)
      else $error("result item exceeds value range");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item present right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with no result item waiting");

endmodule

bind neighbour_mean_grid_smoother nmgs_port_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_nmgs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: sim/nmgs_tb_pkg.sv
`timescale 1ns / 100ps
// Testbench-side codes and sizes for the neighbour mean grid smoother.
// Shared by the checker and the testbench top.
package nmgs_tb_pkg;

   localparam int HEIGHT_W   = 16;
   localparam int SMOOTH_W   = 15;
   localparam int TDATA_W    = 16;
   localparam int LINE_DEPTH = 1024;

   typedef enum logic {
      ACT_CELL  = 1'b0,
      ACT_FLUSH = 1'b1
   } grid_action_type;

endpackage

FILE: sim/nmgs_checker.sv
`timescale 1ns / 100ps
// Checker for the grid smoother: follows register writes and accepted items, predicts
// the smoothed value and grid-end flag of each result and compares them with the block.
// Depends on nmgs_pkg and nmgs_tb_pkg.
module nmgs_checker
   import nmgs_pkg::*;
   import nmgs_tb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   // height_value.
   input  logic [TDATA_W-1:0]  req_tdata,
   // action.
   input  logic                req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   // smoothed_value, zero padded.
   input  logic [TDATA_W-1:0]  rsp_tdata,
   input  logic                rsp_tlast,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata,
   output int                  failures,
   output int                  pending
);

   typedef struct packed {
      logic [SMOOTH_W-1:0] value;
      logic                last;
   } cell_mean_type;

   logic [SMOOTH_W-1:0]     upper_line  [LINE_DEPTH];
   logic [SMOOTH_W-1:0]     center_line [LINE_DEPTH];
   logic [9:0]              column;
   logic [ROW_COUNT_W-1:0]  row;
   logic [ROW_LENGTH_W-1:0] length_reg;
   logic [ROW_COUNT_W-1:0]  rows_reg;
   cell_mean_type           pending_means [$];

   initial begin
      failures = 0;
      foreach (upper_line[i]) begin
         upper_line[i]  = '0;
         center_line[i] = '0;
      end
   end

   function automatic int effective_length();
      if (length_reg == 0) return 1;
      if (length_reg > LINE_DEPTH) return LINE_DEPTH;
      return int'(length_reg);
   endfunction

   function automatic int effective_rows();
      return (rows_reg == 0) ? 1 : int'(rows_reg);
   endfunction

   task automatic restart_grid();
      column = '0;
      row    = '0;
   endtask

   // The cell being finished sits in the center line; its left neighbour has already
   // moved into the upper line.
   function automatic logic [SMOOTH_W-1:0] cross_mean(input int c, input int len,
                                                      input bit has_up, input bit has_down,
                                                      input logic [SMOOTH_W-1:0] below);
      int sum;
      int cells;
      sum   = center_line[c];
      cells = 1;
      if (has_up) begin
         sum += upper_line[c];
         cells++;
      end
      if (has_down) begin
         sum += below;
         cells++;
      end
      if (c > 0) begin
         sum += upper_line[c-1];
         cells++;
      end
      if (c + 1 < len) begin
         sum += center_line[c+1];
         cells++;
      end
      return SMOOTH_W'(sum / cells);
   endfunction

   task automatic advance_grid(input grid_action_type action, input logic [HEIGHT_W-1:0] height);
      int                  len;
      int                  rows;
      int                  c;
      bit                  draining;
      logic [SMOOTH_W-1:0] clamped;
      cell_mean_type       result;
      len  = effective_length();
      rows = effective_rows();
      c    = column;
      if (c >= len) c = len - 1;
      draining = (row >= rows);
      if (action == ACT_CELL) begin
         if (!draining) begin
            clamped = height[HEIGHT_W-1] ? '0 : height[SMOOTH_W-1:0];
            if (row >= 1) begin
               result.value = cross_mean(c, len, row >= 2, 1'b1, clamped);
               result.last  = 1'b0;
               pending_means.push_back(result);
            end
            upper_line[c]  = center_line[c];
            center_line[c] = clamped;
            if (c + 1 >= len) begin
               column = '0;
               row    = row + 1'b1;
            end else begin
               column = 10'(c + 1);
            end
         end
      end else if (draining) begin
         result.value = cross_mean(c, len, rows >= 2, 1'b0, '0);
         result.last  = (c + 1 >= len);
         pending_means.push_back(result);
         upper_line[c] = center_line[c];
         if (c + 1 >= len) begin
            restart_grid();
         end else begin
            column = 10'(c + 1);
         end
      end
   endtask

   always @(posedge clock) begin
      cell_mean_type oldest;
      if (reset) begin
         length_reg = ROW_LENGTH_RESET;
         rows_reg   = ROW_COUNT_RESET;
         restart_grid();
         pending_means.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_means.size() == 0) begin
               $error("result with no cell waiting: smoothed_value %0d, last_of_grid %0b",
                      rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               oldest = pending_means.pop_front();
               if (rsp_tdata !== {1'b0, oldest.value}) begin
                  $error("smoothed_value: expected %0d, actual %0d", oldest.value, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== oldest.last) begin
                  $error("last_of_grid: expected %0b, actual %0b", oldest.last, rsp_tlast);
                  failures++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == REG_ROW_LENGTH) begin
               length_reg = csr_wdata[ROW_LENGTH_W-1:0];
            end else begin
               rows_reg = csr_wdata[ROW_COUNT_W-1:0];
            end
            restart_grid();
         end
         if (req_tvalid && req_tready) begin
            advance_grid(grid_action_type'(req_tuser), req_tdata);
         end
      end
      pending <= pending_means.size();
   end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the neighbour mean grid smoother: drives grids of cells, flush items
// and register writes under several idling patterns and reports the verdict.
// Depends on nmgs_pkg, nmgs_tb_pkg, nmgs_checker and the block itself.
module tb_top;
   import nmgs_pkg::*;
   import nmgs_tb_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 30;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 550;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic [TDATA_W-1:0] req_tdata  = '0;
   logic               req_tuser  = 1'b0;
   logic               rsp_tready = 1'b0;
   logic               csr_we     = 1'b0;
   logic               csr_index  = 1'b0;
   logic [CSR_DW-1:0]  csr_wdata  = '0;
   logic               req_tready;
   logic               rsp_tvalid;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               rsp_tlast;
   int                 failures;
   int                 pending;

   int idle_pct     = 0;
   int stall_pct    = 0;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int quiet_cycles = 0;
   int useful_items = 0;

   always #(HALF_PERIOD) clock = ~clock;

   neighbour_mean_grid_smoother u_top (.*);

   nmgs_checker u_checker (.*);

   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** neighbour_mean_grid_smoother: FAILED **");
            $finish;
         end
      end
   end

   function automatic logic [HEIGHT_W-1:0] random_height();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3, 4:    return {1'b1, 15'($urandom)};
         default: return {1'b0, 15'($urandom)};
      endcase
   endfunction

   task automatic set_idling(input int phase);
      case (phase)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 50; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 50; end
         default: begin idle_pct = 10; stall_pct = 10; end
      endcase
   endtask

   task automatic send_item(input grid_action_type action, input logic [HEIGHT_W-1:0] height);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= height;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(input csr_reg_type index, input logic [CSR_DW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Cells of row 0 leave no result behind, so the pipeline gets time to empty too.
   task automatic configure(input logic [CSR_DW-1:0] len_word, input logic [CSR_DW-1:0] rows_word);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(REG_ROW_LENGTH, len_word);
      write_reg(REG_ROW_COUNT, rows_word);
   endtask

   task automatic run_grid(input logic [CSR_DW-1:0] len_word, input logic [CSR_DW-1:0] rows_word,
                           input int noise_pct, input bit complete, input int pause_cell,
                           input bit hold);
      int len;
      int rows;
      int total;
      int cells;
      int cap;
      len  = int'(len_word[ROW_LENGTH_W-1:0]);
      len  = (len == 0) ? 1 : ((len > LINE_DEPTH) ? LINE_DEPTH : len);
      rows = (rows_word == 0) ? 1 : int'(rows_word);
      total = len * rows;
      configure(len_word, rows_word);
      if (hold) hold_request = 1'b1;
      cap   = (total - 1 < 4 * len) ? total - 1 : 4 * len;
      cells = complete ? total : $urandom_range(cap, 0);
      for (int i = 0; i < cells; i++) begin
         if ($urandom_range(99) < noise_pct) send_item(ACT_FLUSH, random_height());
         if (i == pause_cell) wait_drained();
         send_item(ACT_CELL, random_height());
      end
      useful_items += cells;
      if (complete) begin
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < noise_pct) send_item(ACT_CELL, random_height());
            send_item(ACT_FLUSH, random_height());
         end
         useful_items += len;
      end
   endtask

   initial begin
      logic [HEIGHT_W-1:0] corner_cells [9] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF,
                                                16'h0001, 16'h7FFF, 16'h3039, 16'hFFFE,
                                                16'h7FFF};
      int                  random_start;
      int                  grid_no;
      int                  len;
      int                  rows;
      bit                  complete;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // A 3 x 3 grid with extreme heights, stray flush and cell items and a full pause.
      configure(16'd3, 16'd3);
      send_item(ACT_FLUSH, random_height());
      for (int i = 0; i < 9; i++) begin
         if (i == 5) wait_drained();
         send_item(ACT_CELL, corner_cells[i]);
      end
      send_item(ACT_CELL, 16'h7FFF);
      repeat (3) send_item(ACT_FLUSH, random_height());

      // Zero lengths act as one: a single cell grid.
      configure(16'd0, 16'd0);
      send_item(ACT_CELL, 16'h7FFF);
      send_item(ACT_FLUSH, 16'h8000);

      configure(16'd1, 16'd3);
      send_item(ACT_CELL, 16'hFFFF);
      send_item(ACT_CELL, 16'h7FFF);
      send_item(ACT_CELL, 16'h0064);
      send_item(ACT_FLUSH, 16'h5A5A);

      // The tallest grid is abandoned; the next register write restarts the block.
      configure(16'd2, 16'hFFFF);
      repeat (5) send_item(ACT_CELL, random_height());

      // An oversized row length saturates to the full line store.
      configure(16'h07FF, 16'd2);
      repeat (LINE_DEPTH + 4) send_item(ACT_CELL, random_height());

      set_idling(0);
      run_grid(16'd8, 16'd5, 0, 1'b1, -1, 1'b1);

      random_start = useful_items;
      grid_no      = 0;
      while (useful_items - random_start < RANDOM_ITEMS) begin
         set_idling(grid_no % 4);
         case ($urandom_range(9))
            0:       len = 1;
            1:       len = 2;
            2:       len = 0;
            8, 9:    len = $urandom_range(48, 13);
            default: len = $urandom_range(12, 3);
         endcase
         complete = ($urandom_range(7) != 0);
         if (!complete) begin
            rows = $urandom_range(65535, 1);
         end else if ($urandom_range(9) == 0) begin
            rows = 0;
         end else begin
            rows = $urandom_range(6, 1);
         end
         run_grid({5'($urandom), 11'(len)}, 16'(rows),
                  ($urandom_range(3) == 0) ? 10 : 0, complete,
                  ($urandom_range(15) == 0) ? $urandom_range(len + 8) : -1, 1'b0);
         grid_no++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("** neighbour_mean_grid_smoother: PASSED **");
      end else begin
         $display("** neighbour_mean_grid_smoother: FAILED **");
      end
      $finish;
   end

endmodule
